[src/rdti_pkg.sv]
`default_nettype none

package rdti_pkg;

    localparam int DIGIT_W   = 4;
    localparam int RADIX_W   = 5;
    localparam int STATUS_W  = 2;
    localparam int VALUE_OUT_W = 64;
    localparam int S_DATA_W  = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_DIGIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_BASE  = 2'd3;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last_digit;
    } item_t;

    typedef struct packed {
        logic [VALUE_OUT_W-1:0] value;
        logic [STATUS_W-1:0]    status;
    } result_t;

endpackage

`default_nettype wire

[src/rdti_in_stage.sv]
`default_nettype none

module rdti_in_stage (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [rdti_pkg::DIGIT_W-1:0] s_digit,
    input  wire                         s_last,
    input  wire                         take,
    output logic                        item_valid,
    output rdti_pkg::item_t             item
);

    logic            valid_reg;
    rdti_pkg::item_t item_reg;

    // accept a new word when empty or when the held word leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.digit      <= s_digit;
            item_reg.last_digit <= s_last;
        end
    end

endmodule

`default_nettype wire

[src/rdti_acc.sv]
`default_nettype none

module rdti_acc #(
    parameter int VALUE_WIDTH = 64
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          step,
    input  rdti_pkg::item_t              item,
    input  wire  [rdti_pkg::RADIX_W-1:0] radix,
    output rdti_pkg::result_t            result
);

    localparam int PROD_W = VALUE_WIDTH + rdti_pkg::RADIX_W;

    logic [VALUE_WIDTH-1:0]        acc_reg;
    logic [VALUE_WIDTH-1:0]        acc_next;
    logic [rdti_pkg::STATUS_W-1:0] err_reg;
    logic [rdti_pkg::STATUS_W-1:0] err_next;
    logic [VALUE_WIDTH-1:0]        acc_upd;
    logic [rdti_pkg::STATUS_W-1:0] err_upd;
    logic [PROD_W-1:0]             prod;
    logic [PROD_W-1:0]             sum;
    logic                          base_bad;
    logic                          digit_bad;
    logic                          ovf;

    // product is below 31 * 2^W, so it never wraps PROD_W bits
    assign prod = {{rdti_pkg::RADIX_W{1'b0}}, acc_reg}
                * {{VALUE_WIDTH{1'b0}}, radix};
    assign sum  = prod + {{(PROD_W-rdti_pkg::DIGIT_W){1'b0}}, item.digit};
    assign ovf  = |sum[PROD_W-1:VALUE_WIDTH];

    assign base_bad  = (radix < rdti_pkg::RADIX_MIN) || (radix > rdti_pkg::RADIX_MAX);
    assign digit_bad = {1'b0, item.digit} >= radix;

    always_comb begin
        acc_upd = acc_reg;
        err_upd = err_reg;
        // first error of a number wins; later digits are dropped
        if (err_reg == rdti_pkg::ST_OK) begin
            if (base_bad) begin
                err_upd = rdti_pkg::ST_BAD_BASE;
                acc_upd = '1;
            end else if (digit_bad) begin
                err_upd = rdti_pkg::ST_BAD_DIGIT;
            end else if (ovf) begin
                err_upd = rdti_pkg::ST_OVERFLOW;
                acc_upd = '1;
            end else begin
                acc_upd = sum[VALUE_WIDTH-1:0];
            end
        end
    end

    always_comb begin
        result.value                  = '0;
        result.value[VALUE_WIDTH-1:0] = acc_upd;
        result.status                 = err_upd;
    end

    always_comb begin
        acc_next = acc_reg;
        err_next = err_reg;
        if (step) begin
            if (item.last_digit) begin
                acc_next = '0;
                err_next = rdti_pkg::ST_OK;
            end else begin
                acc_next = acc_upd;
                err_next = err_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            err_reg <= rdti_pkg::ST_OK;
        end else begin
            acc_reg <= acc_next;
            err_reg <= err_next;
        end
    end

endmodule

`default_nettype wire

[src/rdti_out_reg.sv]
`default_nettype none

module rdti_out_reg (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              load,
    input  rdti_pkg::result_t                result,
    output logic                             free,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [rdti_pkg::VALUE_OUT_W-1:0] m_value,
    output logic [rdti_pkg::STATUS_W-1:0]    m_status
);

    logic              valid_reg;
    rdti_pkg::result_t result_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_value  = result_reg.value;
    assign m_status = result_reg.status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

[src/radix_digits_to_integer.sv]
`default_nettype none

// Digit stream to integer converter.
// s_ channel: one digit per word, most significant first, in s_tdata[3:0];
// s_tlast marks the final digit of a number. Each digit updates
// value = radix * value + digit over VALUE_WIDTH bits.
// m_ channel: one word per marked digit: the value in m_tdata (zero above
// VALUE_WIDTH) and the status in m_tuser (ok, bad digit, overflow, bad base).
// cfg channel: writes the 5-bit base; cfg_ready is always high. Write it only
// while no number is in flight.
// A result is registered into the output register as its marked digit leaves the
// digit register. One digit per cycle while m_ does not stall, set by the
// combinational multiply-add that closes the accumulator loop.
// Reset empties both pipeline registers, clears the partial value and the error,
// and sets the base to 10.
// When m_tready is low a held result stalls the digit register, and s_tready
// drops once that register is also full; no word is dropped.
module radix_digits_to_integer #(
    parameter int VALUE_WIDTH = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [3:0] digit, [7:4] zero
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic [1:0]  m_tuser,   // [1:0] status
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [4:0]  cfg_data   // [4:0] radix
);

    logic [rdti_pkg::RADIX_W-1:0] radix_reg;
    logic                         item_valid;
    rdti_pkg::item_t              item;
    rdti_pkg::result_t            result;
    logic                         out_free;
    logic                         take;

    assign cfg_ready = 1'b1;
    assign take      = item_valid && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= rdti_pkg::RADIX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            radix_reg <= cfg_data;
        end
    end

    rdti_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_digit    (s_tdata[rdti_pkg::DIGIT_W-1:0]),
        .s_last     (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    rdti_acc #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (take),
        .item    (item),
        .radix   (radix_reg),
        .result  (result)
    );

    rdti_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take && item.last_digit),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_value  (m_tdata),
        .m_status (m_tuser)
    );

endmodule

`default_nettype wire

[dv/radix_digits_to_integer_test.sv]
`default_nettype none

module radix_digits_to_integer_test;

    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_DIGITS  = 1000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata   = '0;   // [3:0] digit, [7:4] zero
    logic        s_tlast   = 1'b0;
    wire         m_tvalid;
    logic        m_tready  = 1'b0;
    wire  [63:0] m_tdata;          // [63:0] value
    wire  [1:0]  m_tuser;          // [1:0] status
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [4:0]  cfg_data  = '0;   // [4:0] radix

    // Converter state as the block should hold it
    logic [rdti_pkg::RADIX_W-1:0]     base_q    = rdti_pkg::RADIX_RESET;
    logic [rdti_pkg::VALUE_OUT_W-1:0] partial_q = '0;
    logic [rdti_pkg::STATUS_W-1:0]    fault_q   = rdti_pkg::ST_OK;
    rdti_pkg::result_t                pending_results[$];

    int digits_sent   = 0;
    int numbers_done  = 0;
    int bases_written = 0;
    int fail_count    = 0;
    int status_seen[4];
    bit idle_on       = 1'b1;
    int quiet_cycles  = 0;

    radix_digits_to_integer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic int draw_gap();
        return idle_on ? $urandom_range(0, 11) : 0;
    endfunction

    function automatic logic [rdti_pkg::RADIX_W-1:0] pick_radix();
        if ($urandom_range(0, 9) < 8)
            return rdti_pkg::RADIX_W'($urandom_range(2, 16));
        return rdti_pkg::RADIX_W'($urandom_range(0, 31));
    endfunction

    // Longest run of digits whose largest value still fits in 64 bits
    function automatic int max_fit_len(int r);
        logic [69:0] p;
        int          n;
        p = 70'd1;
        n = 0;
        while (p * r <= (70'd1 << 64)) begin
            p = p * r;
            n++;
        end
        return n;
    endfunction

    function automatic void accumulate_digit(logic [rdti_pkg::DIGIT_W-1:0] d, logic last);
        logic [rdti_pkg::VALUE_OUT_W+rdti_pkg::RADIX_W-1:0] wide;
        rdti_pkg::result_t                                  r;
        if (fault_q == rdti_pkg::ST_OK) begin
            wide = {{rdti_pkg::RADIX_W{1'b0}}, partial_q} * base_q + d;
            if (base_q < rdti_pkg::RADIX_MIN || base_q > rdti_pkg::RADIX_MAX) begin
                fault_q   = rdti_pkg::ST_BAD_BASE;
                partial_q = '1;
            end else if ({1'b0, d} >= base_q) begin
                fault_q = rdti_pkg::ST_BAD_DIGIT;
            end else if (wide[rdti_pkg::VALUE_OUT_W+rdti_pkg::RADIX_W-1:rdti_pkg::VALUE_OUT_W]
                         != '0) begin
                fault_q   = rdti_pkg::ST_OVERFLOW;
                partial_q = '1;
            end else begin
                partial_q = wide[rdti_pkg::VALUE_OUT_W-1:0];
            end
        end
        if (last) begin
            r.value  = partial_q;
            r.status = fault_q;
            pending_results.push_back(r);
            partial_q = '0;
            fault_q   = rdti_pkg::ST_OK;
        end
    endfunction

    task automatic send_digit(input logic [rdti_pkg::DIGIT_W-1:0] d, input logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(rdti_pkg::S_DATA_W-rdti_pkg::DIGIT_W){1'b0}}, d};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        accumulate_digit(d, last);
        digits_sent++;
    endtask

    // Send a number written in upper-case hex characters, last one marked
    task automatic send_text(input string txt);
        byte c;
        for (int i = 0; i < txt.len(); i++) begin
            c = txt[i];
            send_digit((c >= "A") ? rdti_pkg::DIGIT_W'(c - "A" + 10)
                                  : rdti_pkg::DIGIT_W'(c - "0"),
                       i == txt.len() - 1);
        end
    endtask

    // Hold off the sender until every result is back and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_radix(input logic [rdti_pkg::RADIX_W-1:0] r);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        base_q = r;
        bases_written++;
    endtask

    task automatic test_default_base();
        send_text("0");
        send_text("9");
        send_text("42");
    endtask

    task automatic test_bad_digit();
        send_text("1A3");
        send_text("F");
    endtask

    task automatic test_bad_base();
        write_radix(5'd0);
        send_text("F");
        write_radix(5'd1);
        send_text("0");
        write_radix(5'd17);
        send_text("1");
        write_radix(5'd31);
        send_text("35");
    endtask

    task automatic test_overflow();
        write_radix(rdti_pkg::RADIX_MAX);
        send_text("FFFFFFFFFFFFFFFFF");
        write_radix(rdti_pkg::RADIX_MIN);
        send_text("10");
    endtask

    task automatic test_radix_change_mid_number();
        write_radix(5'd10);
        send_digit(4'd1, 1'b0);
        send_digit(4'd2, 1'b0);
        write_radix(rdti_pkg::RADIX_MAX);
        send_digit(4'd15, 1'b1);
    endtask

    task automatic test_random_numbers();
        int stop_at;
        int r;
        int len;
        int kind;
        int bad_at;
        logic [rdti_pkg::DIGIT_W-1:0] d;
        stop_at = digits_sent + RANDOM_DIGITS;
        while (digits_sent < stop_at) begin
            if ($urandom_range(0, 19) == 0)
                write_radix(pick_radix());
            if ($urandom_range(0, 24) == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            r    = base_q;
            kind = $urandom_range(0, 9);
            if (r < 2 || r > 16)
                kind = 9;
            if (kind == 8 && r == 16)
                kind = 0;
            case (kind)
                6, 7:    len = max_fit_len(r) + $urandom_range(0, 1);
                9:       len = $urandom_range(1, 6);
                default: len = ($urandom_range(0, 15) == 0)
                               ? $urandom_range(9, max_fit_len(r) + 1)
                               : $urandom_range(1, 8);
            endcase
            bad_at = $urandom_range(0, len - 1);
            for (int i = 0; i < len; i++) begin
                case (kind)
                    6, 7:    d = rdti_pkg::DIGIT_W'(r - 1);
                    8:       d = (i == bad_at) ? rdti_pkg::DIGIT_W'($urandom_range(r, 15))
                                               : rdti_pkg::DIGIT_W'($urandom_range(0, r - 1));
                    9:       d = rdti_pkg::DIGIT_W'($urandom_range(0, 15));
                    default: d = rdti_pkg::DIGIT_W'($urandom_range(0, r - 1));
                endcase
                // switch the base between digits of one number now and then
                if (i == 1 && $urandom_range(0, 29) == 0)
                    write_radix(pick_radix());
                send_digit(d, i == len - 1);
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin : result_checker
        rdti_pkg::result_t exp_r;
        int                gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_results.size() == 0) begin
                $error("unexpected word: value %h status %0d", m_tdata, m_tuser);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata !== exp_r.value) begin
                    $error("value: expected %h, got %h", exp_r.value, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
                    fail_count++;
                end
                status_seen[exp_r.status]++;
                numbers_done++;
            end
        end
    end

    // Give up when nothing moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("radix_digits_to_integer: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_base();
        test_bad_digit();
        test_bad_base();
        test_overflow();
        test_radix_change_mid_number();
        test_random_numbers();
        settle();
        $display("Converted %0d numbers from %0d digits across %0d base writes",
                 numbers_done, digits_sent, bases_written);
        $display("Status mix: ok %0d, bad digit %0d, overflow %0d, bad base %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fail_count == 0)
            $display("radix_digits_to_integer: match");
        else
            $display("radix_digits_to_integer: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
